[rtl/core/hcfb_pkg.sv]
// host command frame builder package
// slot codes, register indexes and the work register type
// no dependencies
`default_nettype none

package hcfb_pkg;

  localparam int unsigned MaxPayload = 254;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgIdxW    = 2;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [3:0]         slot_t;

  // register indexes
  localparam cfg_idx_t CfgPreamble  = 2'd0;
  localparam cfg_idx_t CfgStartTwo  = 2'd1;
  localparam cfg_idx_t CfgDirection = 2'd2;
  localparam cfg_idx_t CfgPostamble = 2'd3;

  // output slots of one frame, in stream order
  localparam slot_t SlotPre  = 4'd0;
  localparam slot_t SlotSc1  = 4'd1;
  localparam slot_t SlotSc2  = 4'd2;
  localparam slot_t SlotLen  = 4'd3;
  localparam slot_t SlotLcs  = 4'd4;
  localparam slot_t SlotDir  = 4'd5;
  localparam slot_t SlotData = 4'd6;
  localparam slot_t SlotDcs  = 4'd7;
  localparam slot_t SlotPost = 4'd8;

  typedef struct packed {
    byte_t data;
    byte_t len_byte;
    byte_t dcs;
    slot_t slot;
    slot_t last_slot;
  } work_t;

endpackage

`default_nettype wire

[rtl/core/host_command_frame_builder.sv]
// host command frame builder: wraps command bytes in a normal information frame
// channels: in (data_byte, frame_length), out (out_byte, end_of_frame, end_of_run)
// depends on hcfb_pkg
//
// usage: one command byte per input item. the first item of a frame yields
// preamble, start code one, start code two, len, lcs, direction byte and the
// data byte; later items yield the data byte alone. the item that closes the
// frame adds the data checksum and the postamble (end_of_frame set).
// end_of_run marks the last result of each item.
// an accepted item sits in a work register and leaves one result per cycle
// through the output register while the output is not stalled. the next item
// is taken in the cycle its predecessor's last result moves to the output
// register, so pass-through bytes flow one per cycle while the output is not
// stalled.
// when out_ready_i is low the output register holds and the work register
// waits behind it; in_ready_o drops once the work register is occupied.
// reset empties both registers, closes any open frame and restores the
// configuration registers to their defaults.
`default_nettype none

module host_command_frame_builder (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire hcfb_pkg::cfg_idx_t cfg_index_i,
  input  wire hcfb_pkg::byte_t  cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire hcfb_pkg::byte_t  data_byte_i,
  input  wire hcfb_pkg::byte_t  frame_length_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output hcfb_pkg::byte_t       out_byte_o,
  output logic                  end_of_frame_o,
  output logic                  end_of_run_o
);
  import hcfb_pkg::*;

  byte_t preamble_q, start_two_q, direction_q, postamble_q;

  logic  in_frame_q, in_frame_d;
  byte_t bytes_left_q, bytes_left_d;
  byte_t sum_q, sum_d;

  logic  work_valid_q, work_valid_d;
  work_t work_q, work_d;

  logic  out_valid_q, out_valid_d;
  byte_t out_byte_q, out_byte_d;
  logic  eof_q, eof_d, eor_q, eor_d;

  logic  in_acc, load_out, work_done;
  byte_t len_clamp, len_byte, bl_sel, bl_next, sum_base, sum_new, slot_byte;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q  <= 8'h00;
      start_two_q <= 8'hFF;
      direction_q <= 8'hD4;
      postamble_q <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPreamble:  preamble_q  <= cfg_data_i;
        CfgStartTwo:  start_two_q <= cfg_data_i;
        CfgDirection: direction_q <= cfg_data_i;
        CfgPostamble: postamble_q <= cfg_data_i;
        default:      preamble_q  <= preamble_q;
      endcase
    end
  end

  assign load_out   = work_valid_q && (!out_valid_q || out_ready_i);
  assign work_done  = load_out && (work_q.slot == work_q.last_slot);
  assign in_ready_o = !work_valid_q || work_done;
  assign in_acc     = in_valid_i && in_ready_o;

  // frame bookkeeping for the incoming item
  always_comb begin
    priority if (frame_length_i == 8'd0) begin
      len_clamp = 8'd1;
    end else if (frame_length_i > ByteW'(MaxPayload)) begin
      len_clamp = ByteW'(MaxPayload);
    end else begin
      len_clamp = frame_length_i;
    end
    len_byte = len_clamp + 8'd1;
    sum_base = in_frame_q ? sum_q : (preamble_q + preamble_q + start_two_q + direction_q);
    sum_new  = sum_base + data_byte_i;
    bl_sel   = in_frame_q ? bytes_left_q : len_clamp;
    bl_next  = (bl_sel != 8'd0) ? (bl_sel - 8'd1) : 8'd0;
  end

  always_comb begin
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    sum_d        = sum_q;
    work_valid_d = work_valid_q;
    work_d       = work_q;
    if (in_acc) begin
      work_valid_d       = 1'b1;
      work_d.data        = data_byte_i;
      work_d.len_byte    = len_byte;
      work_d.dcs         = ~sum_new;
      work_d.slot        = in_frame_q ? SlotData : SlotPre;
      work_d.last_slot   = (bl_next == 8'd0) ? SlotPost : SlotData;
      bytes_left_d       = bl_next;
      in_frame_d         = (bl_next != 8'd0);
      sum_d              = (bl_next == 8'd0) ? 8'd0 : sum_new;
    end else if (work_done) begin
      work_valid_d = 1'b0;
    end else if (load_out) begin
      work_d.slot = work_q.slot + 4'd1;
    end
  end

  // byte of the current slot
  always_comb begin
    unique case (work_q.slot)
      SlotPre, SlotSc1: slot_byte = preamble_q;
      SlotSc2:          slot_byte = start_two_q;
      SlotLen:          slot_byte = work_q.len_byte;
      SlotLcs:          slot_byte = 8'd0 - work_q.len_byte;
      SlotDir:          slot_byte = direction_q;
      SlotData:         slot_byte = work_q.data;
      SlotDcs:          slot_byte = work_q.dcs;
      SlotPost:         slot_byte = postamble_q;
      default:          slot_byte = work_q.data;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    eof_d       = eof_q;
    eor_d       = eor_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_byte_d  = slot_byte;
      eof_d       = (work_q.slot == SlotPost);
      eor_d       = (work_q.slot == work_q.last_slot);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= 8'd0;
      sum_q        <= 8'd0;
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_byte_q <= out_byte_d;
    eof_q      <= eof_d;
    eor_q      <= eor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign end_of_frame_o = eof_q;
  assign end_of_run_o   = eor_q;

`ifndef SYNTH
  a_frame_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q == (bytes_left_q != 8'd0))
    else $error("open frame and byte count disagree");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q |-> (work_q.slot <= work_q.last_slot))
    else $error("work slot ran past its last slot");

  a_eof_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_frame_o) |-> end_of_run_o)
    else $error("postamble not marked as end of run");

  a_header_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_frame_q) |=> (work_q.slot == SlotPre))
    else $error("frame start did not begin with the preamble");
`endif

endmodule

`default_nettype wire
